### sv/tslr_pkg.sv
package tslr_pkg;

  localparam int VIDEO_BYTES    = 8192;
  localparam int SPRITE_BYTES   = 160;
  localparam int LINE_WIDTH     = 160;
  localparam int TILES_PER_LINE = 20;
  localparam int SPRITE_COUNT   = 40;
  localparam int VADDR_W        = 13;
  localparam int SADDR_W        = 8;
  localparam int GRP_W          = 5;
  localparam int CFG_AW         = 4;

  localparam logic [GRP_W-1:0]   LAST_GROUP = GRP_W'(TILES_PER_LINE - 1);
  localparam logic [VADDR_W-1:0] MAP_LOW    = 13'h1800;
  localparam logic [VADDR_W-1:0] MAP_HIGH   = 13'h1C00;
  localparam logic [VADDR_W-1:0] TILE_SIGNED_BASE = 13'h0800;

  typedef enum logic [1:0] {
    OP_VRAM_WR   = 2'd0,
    OP_SPRITE_WR = 2'd1,
    OP_RENDER    = 2'd2,
    OP_NONE      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_BG_ENABLE     = 2'd0,
    REG_SPRITE_ENABLE = 2'd1,
    REG_BG_MAP_HIGH   = 2'd2,
    REG_TILE_UNSIGNED = 2'd3
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_BG_CLR,
    S_BG_MAP,
    S_BG_LO,
    S_BG_HI,
    S_BG_WR,
    S_SP_Y,
    S_SP_X,
    S_SP_T,
    S_SP_A,
    S_SP_CHK,
    S_SP_HI,
    S_SP_RD0,
    S_SP_WR0,
    S_SP_WR1,
    S_OUT_RD,
    S_OUT_LD
  } state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [12:0] address;
    logic [7:0]  data;
    logic [7:0]  line;
  } in_item_t;

  typedef struct packed {
    logic [15:0] pixel_group;
    logic [4:0]  group_index;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic bg_enable;
    logic sprite_enable;
    logic bg_map_high;
    logic tile_data_unsigned;
  } cfg_t;

  // line buffer access from the sequencer
  typedef struct packed {
    logic             rd_en;
    logic [GRP_W-1:0] rd_addr;
    logic             wr_en;
    logic [GRP_W-1:0] wr_addr;
    logic [15:0]      wr_data;
  } line_req_t;

  // two tile bytes into eight 2-bit pixels, leftmost in bits 15:14
  function automatic logic [15:0] tile_pixels(input logic [7:0] lo, input logic [7:0] hi);
    logic [15:0] res;
    res = '0;
    for (int i = 0; i < 8; i++) begin
      res[15-2*i -: 2] = {hi[7-i], lo[7-i]};
    end
    return res;
  endfunction

  // overlay one sprite row onto one group of eight columns
  function automatic logic [15:0] sprite_merge(input logic [15:0] old, input logic [7:0] lo,
                                               input logic [7:0] hi, input logic [7:0] left,
                                               input logic [GRP_W-1:0] grp, input logic behind);
    logic [8:0]  x;
    logic [8:0]  c;
    logic [2:0]  ci;
    logic [1:0]  p;
    logic [1:0]  cur;
    logic [15:0] res;
    res = old;
    for (int i = 0; i < 8; i++) begin
      x   = {1'b0, grp, 3'(i)};
      c   = x - {1'b0, left};
      ci  = c[2:0];
      cur = old[15-2*i -: 2];
      p   = {hi[3'd7 - ci], lo[3'd7 - ci]};
      if (c[8:3] == 6'd0 && p != 2'd0 && (!behind || cur == 2'd0)) begin
        res[15-2*i -: 2] = p;
      end
    end
    return res;
  endfunction

endpackage

### sv/tile_sprite_line_renderer.sv
// Channel   Direction  Payload               Handshake
// in_       input      in_item_t (op, addr)  in_valid / in_stall
// out_      output     out_item_t (pixels)   out_valid / out_stall
// config    input      4 x 1-bit registers   APB psel/penable, pready tied high
//
// A render clears the line buffer (background off) or makes three video memory reads per
// tile, then four sprite table reads per sprite plus a merge into one or two groups per
// sprite on the line when sprites are on, then one line buffer read per output group,
// all through the single read ports of the video memory and line buffer.
// Reset clears control and registers; memories hold no defined value until written.
// in_stall is high while a render runs; a pending result may sit in the output register.
module tile_sprite_line_renderer #(
  parameter int SPRITE_COUNT = tslr_pkg::SPRITE_COUNT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  tslr_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output tslr_pkg::out_item_t         out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tslr_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  tslr_pkg::cfg_t     cfg_r;
  tslr_pkg::reg_idx_t reg_sel;
  tslr_pkg::line_req_t line_req;

  logic        in_xfer;
  logic        idle;
  logic        vram_rd_en;
  logic [tslr_pkg::VADDR_W-1:0] vram_rd_addr;
  logic [7:0]  vram_q;
  logic        st_rd_en;
  logic [tslr_pkg::SADDR_W-1:0] st_rd_addr;
  logic [7:0]  st_q;
  logic [15:0] line_q;
  logic        vram_wr_en;
  logic        st_wr_en;
  logic        render_start;

  assign in_stall = !idle;
  assign in_xfer  = in_valid && !in_stall;
  assign pready   = 1'b1;
  assign reg_sel  = tslr_pkg::reg_idx_t'(paddr[3:2]);

  assign vram_wr_en   = in_xfer && (in_data.operation == tslr_pkg::OP_VRAM_WR);
  assign st_wr_en     = in_xfer && (in_data.operation == tslr_pkg::OP_SPRITE_WR)
                     && (in_data.address < 13'(tslr_pkg::SPRITE_BYTES));
  assign render_start = in_xfer && (in_data.operation == tslr_pkg::OP_RENDER);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        tslr_pkg::REG_BG_ENABLE:     cfg_r.bg_enable          <= pwdata[0];
        tslr_pkg::REG_SPRITE_ENABLE: cfg_r.sprite_enable      <= pwdata[0];
        tslr_pkg::REG_BG_MAP_HIGH:   cfg_r.bg_map_high        <= pwdata[0];
        tslr_pkg::REG_TILE_UNSIGNED: cfg_r.tile_data_unsigned <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      tslr_pkg::REG_BG_ENABLE:     prdata[0] = cfg_r.bg_enable;
      tslr_pkg::REG_SPRITE_ENABLE: prdata[0] = cfg_r.sprite_enable;
      tslr_pkg::REG_BG_MAP_HIGH:   prdata[0] = cfg_r.bg_map_high;
      tslr_pkg::REG_TILE_UNSIGNED: prdata[0] = cfg_r.tile_data_unsigned;
      default: ;
    endcase
  end

  tslr_vram u_vram (
    .clk     (clk),
    .wr_en   (vram_wr_en),
    .wr_addr (in_data.address),
    .wr_data (in_data.data),
    .rd_en   (vram_rd_en),
    .rd_addr (vram_rd_addr),
    .rd_data (vram_q)
  );

  tslr_sprite_ram u_sprite_ram (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (in_data.address[7:0]),
    .wr_data (in_data.data),
    .rd_en   (st_rd_en),
    .rd_addr (st_rd_addr),
    .rd_data (st_q)
  );

  tslr_line_buf u_line_buf (
    .clk     (clk),
    .req     (line_req),
    .rd_data (line_q)
  );

  tslr_seq #(
    .SPRITE_COUNT (SPRITE_COUNT)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (render_start),
    .start_line   (in_data.line),
    .cfg          (cfg_r),
    .vram_rd_en   (vram_rd_en),
    .vram_rd_addr (vram_rd_addr),
    .vram_q       (vram_q),
    .st_rd_en     (st_rd_en),
    .st_rd_addr   (st_rd_addr),
    .st_q         (st_q),
    .line_req     (line_req),
    .line_q       (line_q),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_data     (out_data),
    .idle         (idle)
  );

  // a render holds off the input channel
  a_render_busy: assert property (@(posedge clk) disable iff (!rst_n)
    render_start |=> in_stall)
    else $error("input not held off after render start");

  // last flag marks the final group
  a_last_group: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last == (out_data.group_index == tslr_pkg::LAST_GROUP)))
    else $error("last flag does not match group index");

  // group index stays on the line
  a_group_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.group_index <= tslr_pkg::LAST_GROUP))
    else $error("group index past end of line");

endmodule

### sv/tslr_vram.sv
module tslr_vram (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [tslr_pkg::VADDR_W-1:0]     wr_addr,
  input  logic [7:0]                       wr_data,
  input  logic                             rd_en,
  input  logic [tslr_pkg::VADDR_W-1:0]     rd_addr,
  output logic [7:0]                       rd_data
);

  logic [7:0] mem [tslr_pkg::VIDEO_BYTES];

  // byte write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sv/tslr_sprite_ram.sv
module tslr_sprite_ram (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [tslr_pkg::SADDR_W-1:0] wr_addr,
  input  logic [7:0]                   wr_data,
  input  logic                         rd_en,
  input  logic [tslr_pkg::SADDR_W-1:0] rd_addr,
  output logic [7:0]                   rd_data
);

  logic [7:0] mem [tslr_pkg::SPRITE_BYTES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sv/tslr_line_buf.sv
module tslr_line_buf (
  input  logic                clk,
  input  tslr_pkg::line_req_t req,
  output logic [15:0]         rd_data
);

  logic [15:0] mem [tslr_pkg::TILES_PER_LINE];

  // one group of eight pixels per entry
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

### sv/tslr_seq.sv
module tslr_seq #(
  parameter int SPRITE_COUNT = tslr_pkg::SPRITE_COUNT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [7:0]                    start_line,
  input  tslr_pkg::cfg_t                cfg,
  output logic                          vram_rd_en,
  output logic [tslr_pkg::VADDR_W-1:0]  vram_rd_addr,
  input  logic [7:0]                    vram_q,
  output logic                          st_rd_en,
  output logic [tslr_pkg::SADDR_W-1:0]  st_rd_addr,
  input  logic [7:0]                    st_q,
  output tslr_pkg::line_req_t           line_req,
  input  logic [15:0]                   line_q,
  input  logic                          out_stall,
  output logic                          out_valid,
  output tslr_pkg::out_item_t           out_data,
  output logic                          idle
);

  localparam int KW = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;
  localparam logic [KW-1:0] LAST_SPRITE = KW'(SPRITE_COUNT - 1);

  tslr_pkg::state_t state_r, state_nxt;

  logic [tslr_pkg::GRP_W-1:0]   grp_r;
  logic [KW-1:0]                spr_r;
  logic [7:0]                   line_r;
  logic [7:0]                   lo_r;
  logic [7:0]                   hi_r;
  logic [7:0]                   spr_y_r;
  logic [7:0]                   left_r;
  logic [7:0]                   spr_tile_r;
  logic                         behind_r;
  logic [tslr_pkg::VADDR_W-1:0] addr_r;
  logic                         out_valid_r;
  tslr_pkg::out_item_t          out_data_r;

  logic [tslr_pkg::VADDR_W-1:0] map_addr;
  logic [tslr_pkg::VADDR_W-1:0] tile_addr;
  logic [tslr_pkg::VADDR_W-1:0] spr_addr;
  logic [7:0]                   spr_top;
  logic [8:0]                   row_diff;
  logic [tslr_pkg::GRP_W-1:0]   ga;
  logic                         spr_hit;
  logic                         spr_second;
  logic                         grp_last;
  logic                         spr_last;
  logic                         out_free;
  logic [7:0]                   spr_base;

  // address arithmetic
  assign map_addr = (cfg.bg_map_high ? tslr_pkg::MAP_HIGH : tslr_pkg::MAP_LOW)
                  + {3'd0, line_r[7:3], 5'd0} + 13'(grp_r);
  assign tile_addr = cfg.tile_data_unsigned
                   ? ({1'b0, vram_q, 4'd0} + {9'd0, line_r[2:0], 1'b0})
                   : (tslr_pkg::TILE_SIGNED_BASE + {1'b0, vram_q ^ 8'h80, 4'd0}
                      + {9'd0, line_r[2:0], 1'b0});
  assign spr_top  = spr_y_r - 8'h10;
  assign row_diff = {1'b0, line_r} - {1'b0, spr_top};
  assign ga       = left_r[7:3];
  assign spr_hit  = (row_diff[8:3] == 6'd0) && (ga <= tslr_pkg::LAST_GROUP);
  assign spr_addr = {1'b0, spr_tile_r, 4'd0} + {9'd0, row_diff[2:0], 1'b0};
  assign spr_second = (left_r[2:0] != 3'd0) && (ga < tslr_pkg::LAST_GROUP);
  assign grp_last = (grp_r == tslr_pkg::LAST_GROUP);
  assign spr_last = (spr_r == LAST_SPRITE);
  assign out_free = !out_valid_r || !out_stall;
  assign spr_base = 8'(spr_r) << 2;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tslr_pkg::S_IDLE: begin
        if (start) state_nxt = cfg.bg_enable ? tslr_pkg::S_BG_MAP : tslr_pkg::S_BG_CLR;
      end
      tslr_pkg::S_BG_CLR, tslr_pkg::S_BG_WR: begin
        if (grp_last) begin
          state_nxt = cfg.sprite_enable ? tslr_pkg::S_SP_Y : tslr_pkg::S_OUT_RD;
        end else if (state_r == tslr_pkg::S_BG_WR) begin
          state_nxt = tslr_pkg::S_BG_MAP;
        end
      end
      tslr_pkg::S_BG_MAP: state_nxt = tslr_pkg::S_BG_LO;
      tslr_pkg::S_BG_LO:  state_nxt = tslr_pkg::S_BG_HI;
      tslr_pkg::S_BG_HI:  state_nxt = tslr_pkg::S_BG_WR;
      tslr_pkg::S_SP_Y:   state_nxt = tslr_pkg::S_SP_X;
      tslr_pkg::S_SP_X:   state_nxt = tslr_pkg::S_SP_T;
      tslr_pkg::S_SP_T:   state_nxt = tslr_pkg::S_SP_A;
      tslr_pkg::S_SP_A:   state_nxt = tslr_pkg::S_SP_CHK;
      tslr_pkg::S_SP_CHK: begin
        if (spr_hit) state_nxt = tslr_pkg::S_SP_HI;
        else state_nxt = spr_last ? tslr_pkg::S_OUT_RD : tslr_pkg::S_SP_Y;
      end
      tslr_pkg::S_SP_HI:  state_nxt = tslr_pkg::S_SP_RD0;
      tslr_pkg::S_SP_RD0: state_nxt = tslr_pkg::S_SP_WR0;
      tslr_pkg::S_SP_WR0: begin
        if (spr_second) state_nxt = tslr_pkg::S_SP_WR1;
        else state_nxt = spr_last ? tslr_pkg::S_OUT_RD : tslr_pkg::S_SP_Y;
      end
      tslr_pkg::S_SP_WR1: state_nxt = spr_last ? tslr_pkg::S_OUT_RD : tslr_pkg::S_SP_Y;
      tslr_pkg::S_OUT_RD: state_nxt = tslr_pkg::S_OUT_LD;
      tslr_pkg::S_OUT_LD: begin
        if (out_free) state_nxt = grp_last ? tslr_pkg::S_IDLE : tslr_pkg::S_OUT_RD;
      end
      default: state_nxt = tslr_pkg::S_IDLE;
    endcase
  end

  // memory port controls
  always_comb begin
    vram_rd_en   = 1'b0;
    vram_rd_addr = map_addr;
    st_rd_en     = 1'b0;
    st_rd_addr   = spr_base;
    line_req     = '0;
    unique case (state_r)
      tslr_pkg::S_BG_CLR: begin
        line_req.wr_en   = 1'b1;
        line_req.wr_addr = grp_r;
      end
      tslr_pkg::S_BG_MAP: vram_rd_en = 1'b1;
      tslr_pkg::S_BG_LO: begin
        vram_rd_en   = 1'b1;
        vram_rd_addr = tile_addr;
      end
      tslr_pkg::S_BG_HI: begin
        vram_rd_en   = 1'b1;
        vram_rd_addr = addr_r + 13'd1;
      end
      tslr_pkg::S_BG_WR: begin
        line_req.wr_en   = 1'b1;
        line_req.wr_addr = grp_r;
        line_req.wr_data = tslr_pkg::tile_pixels(lo_r, vram_q);
      end
      tslr_pkg::S_SP_Y: st_rd_en = 1'b1;
      tslr_pkg::S_SP_X: begin
        st_rd_en   = 1'b1;
        st_rd_addr = spr_base | 8'd1;
      end
      tslr_pkg::S_SP_T: begin
        st_rd_en   = 1'b1;
        st_rd_addr = spr_base | 8'd2;
      end
      tslr_pkg::S_SP_A: begin
        st_rd_en   = 1'b1;
        st_rd_addr = spr_base | 8'd3;
      end
      tslr_pkg::S_SP_CHK: begin
        vram_rd_en   = spr_hit;
        vram_rd_addr = spr_addr;
      end
      tslr_pkg::S_SP_HI: begin
        vram_rd_en   = 1'b1;
        vram_rd_addr = addr_r + 13'd1;
      end
      tslr_pkg::S_SP_RD0: begin
        line_req.rd_en   = 1'b1;
        line_req.rd_addr = ga;
      end
      tslr_pkg::S_SP_WR0: begin
        line_req.wr_en   = 1'b1;
        line_req.wr_addr = ga;
        line_req.wr_data = tslr_pkg::sprite_merge(line_q, lo_r, hi_r, left_r, ga, behind_r);
        line_req.rd_en   = spr_second;
        line_req.rd_addr = ga + 5'd1;
      end
      tslr_pkg::S_SP_WR1: begin
        line_req.wr_en   = 1'b1;
        line_req.wr_addr = ga + 5'd1;
        line_req.wr_data = tslr_pkg::sprite_merge(line_q, lo_r, hi_r, left_r, ga + 5'd1,
                                                  behind_r);
      end
      tslr_pkg::S_OUT_RD: begin
        line_req.rd_en   = 1'b1;
        line_req.rd_addr = grp_r;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tslr_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == tslr_pkg::S_OUT_LD && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // counters and datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      tslr_pkg::S_IDLE: begin
        line_r <= start_line;
        grp_r  <= '0;
        spr_r  <= '0;
      end
      tslr_pkg::S_BG_CLR, tslr_pkg::S_BG_WR: begin
        grp_r <= grp_last ? '0 : grp_r + 5'd1;
      end
      tslr_pkg::S_BG_LO: addr_r <= tile_addr;
      tslr_pkg::S_BG_HI: lo_r <= vram_q;
      tslr_pkg::S_SP_X: spr_y_r <= st_q;
      tslr_pkg::S_SP_T: left_r <= st_q - 8'h08;
      tslr_pkg::S_SP_A: spr_tile_r <= st_q;
      tslr_pkg::S_SP_CHK: begin
        behind_r <= st_q[7];
        addr_r   <= spr_addr;
        if (!spr_hit) spr_r <= spr_r + KW'(1);
      end
      tslr_pkg::S_SP_HI: lo_r <= vram_q;
      tslr_pkg::S_SP_RD0: hi_r <= vram_q;
      tslr_pkg::S_SP_WR0: begin
        if (!spr_second) spr_r <= spr_r + KW'(1);
      end
      tslr_pkg::S_SP_WR1: spr_r <= spr_r + KW'(1);
      tslr_pkg::S_OUT_LD: begin
        if (out_free) begin
          out_data_r.pixel_group <= line_q;
          out_data_r.group_index <= grp_r;
          out_data_r.last        <= grp_last;
          grp_r                  <= grp_r + 5'd1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign idle      = (state_r == tslr_pkg::S_IDLE);

endmodule

### tb/sv/tb_tile_sprite_line_renderer.sv
module tb_tile_sprite_line_renderer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 60;

  // one row of the directed table; blank rows expect a typed all-zero line of pixels
  typedef struct {
    tslr_pkg::op_t op;
    logic [12:0] addr;
    logic [7:0]  data;
    logic [7:0]  line;
    bit          blank;
  } step_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  tslr_pkg::in_item_t in_data;
  logic out_valid;
  logic out_stall;
  tslr_pkg::out_item_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [tslr_pkg::CFG_AW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  // shadow copies of memories and registers
  logic [7:0] vram_img [tslr_pkg::VIDEO_BYTES];
  logic [7:0] oam_img [tslr_pkg::SPRITE_BYTES];
  logic [1:0] line_px [tslr_pkg::LINE_WIDTH];
  tslr_pkg::cfg_t      cfg_img;
  tslr_pkg::out_item_t pending_groups[$];

  int err_cnt;
  int cycles;
  int rx_max;
  int tx_max;
  int long_hold;

  tile_sprite_line_renderer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  // background tiles, then sprites in table order, then 20 groups
  function automatic void render_line(input logic [7:0] y);
    logic [12:0] map_base;
    logic [12:0] a;
    logic [7:0]  idx;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [7:0]  top;
    logic [7:0]  left;
    int          row;
    int          x;
    bit          behind;
    logic [1:0]  p;
    tslr_pkg::out_item_t grp;
    map_base = cfg_img.bg_map_high ? tslr_pkg::MAP_HIGH : tslr_pkg::MAP_LOW;
    for (int i = 0; i < tslr_pkg::LINE_WIDTH; i++) line_px[i] = 2'd0;
    if (cfg_img.bg_enable) begin
      for (int t = 0; t < tslr_pkg::TILES_PER_LINE; t++) begin
        a   = 13'(int'(map_base) + int'(y >> 3) * 32 + t);
        idx = vram_img[a];
        if (cfg_img.tile_data_unsigned) a = 13'(int'(idx) * 16 + int'(y[2:0]) * 2);
        else a = 13'(int'(tslr_pkg::TILE_SIGNED_BASE) + int'(idx ^ 8'h80) * 16
                      + int'(y[2:0]) * 2);
        lo = vram_img[a];
        hi = vram_img[13'(a + 13'd1)];
        for (int c = 0; c < 8; c++) line_px[t*8+c] = {hi[7-c], lo[7-c]};
      end
    end
    if (cfg_img.sprite_enable) begin
      for (int k = 0; k < tslr_pkg::SPRITE_COUNT; k++) begin
        top = oam_img[4*k] - 8'd16;
        row = int'(y) - int'(top);
        if (row < 0 || row > 7) continue;
        left   = oam_img[4*k+1] - 8'd8;
        behind = oam_img[4*k+3][7];
        a  = 13'(int'(oam_img[4*k+2]) * 16 + row * 2);
        lo = vram_img[a];
        hi = vram_img[13'(a + 13'd1)];
        for (int c = 0; c < 8; c++) begin
          x = int'(left) + c;
          if (x >= tslr_pkg::LINE_WIDTH) continue;
          p = {hi[7-c], lo[7-c]};
          if ((!behind || line_px[x] == 2'd0) && p != 2'd0) line_px[x] = p;
        end
      end
    end
    for (int g = 0; g < tslr_pkg::TILES_PER_LINE; g++) begin
      grp.pixel_group = '0;
      for (int c = 0; c < 8; c++) grp.pixel_group[15-2*c -: 2] = line_px[g*8+c];
      grp.group_index = tslr_pkg::GRP_W'(g);
      grp.last        = (g == tslr_pkg::TILES_PER_LINE - 1);
      pending_groups.push_back(grp);
    end
  endfunction

  // update shadows on an accepted transfer
  function automatic void absorb(input tslr_pkg::in_item_t it, input bit blank);
    tslr_pkg::out_item_t grp;
    case (tslr_pkg::op_t'(it.operation))
      tslr_pkg::OP_VRAM_WR:   vram_img[it.address] = it.data;
      tslr_pkg::OP_SPRITE_WR: begin
        if (it.address < tslr_pkg::SPRITE_BYTES) oam_img[it.address] = it.data;
      end
      tslr_pkg::OP_RENDER: begin
        if (blank) begin
          for (int g = 0; g < tslr_pkg::TILES_PER_LINE; g++) begin
            grp.pixel_group = 16'h0000;
            grp.group_index = tslr_pkg::GRP_W'(g);
            grp.last        = (g == tslr_pkg::TILES_PER_LINE - 1);
            pending_groups.push_back(grp);
          end
        end else begin
          render_line(it.line);
        end
      end
      default: ;
    endcase
  endfunction

  // valid stays up across back-to-back transfers
  task automatic send(input tslr_pkg::in_item_t it, input int gap, input bit blank);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    absorb(it, blank);
  endtask

  task automatic reg_write(input tslr_pkg::reg_idx_t r, input logic v);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= tslr_pkg::CFG_AW'(4 * int'(r));
    pwdata  <= {31'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      tslr_pkg::REG_BG_ENABLE:     cfg_img.bg_enable = v;
      tslr_pkg::REG_SPRITE_ENABLE: cfg_img.sprite_enable = v;
      tslr_pkg::REG_BG_MAP_HIGH:   cfg_img.bg_map_high = v;
      default:                     cfg_img.tile_data_unsigned = v;
    endcase
  endtask

  // wait for the block to go quiet
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_groups.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_cfg(input logic [3:0] v);
    drain();
    reg_write(tslr_pkg::REG_BG_ENABLE, v[3]);
    reg_write(tslr_pkg::REG_SPRITE_ENABLE, v[2]);
    reg_write(tslr_pkg::REG_BG_MAP_HIGH, v[1]);
    reg_write(tslr_pkg::REG_TILE_UNSIGNED, v[0]);
  endtask

  function automatic tslr_pkg::in_item_t rand_item();
    tslr_pkg::in_item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    it.address = 13'($urandom);
    it.data    = 8'($urandom);
    it.line    = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(144, 255))
                                             : 8'($urandom_range(0, 143));
    if (pick < 30) begin
      it.operation = tslr_pkg::OP_RENDER;
    end else if (pick < 65) begin
      it.operation = tslr_pkg::OP_SPRITE_WR;
      if ($urandom_range(0, 9) != 0) begin
        it.address = 13'($urandom_range(0, tslr_pkg::SPRITE_BYTES - 1));
        // keep most sprites on the visible lines
        if (it.address[1:0] == 2'd0 && $urandom_range(0, 3) != 0)
          it.data = 8'($urandom_range(8, 160));
      end
    end else if (pick < 95) begin
      it.operation = tslr_pkg::OP_VRAM_WR;
    end else begin
      it.operation = tslr_pkg::OP_NONE;
    end
    return it;
  endfunction

  // result checker
  always @(negedge clk) begin
    tslr_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_groups.size() == 0) begin
        report($sformatf("unexpected group %0d", out_data.group_index));
      end else begin
        want = pending_groups.pop_front();
        if (out_data.pixel_group !== want.pixel_group)
          report($sformatf("group %0d pixels %h, want %h", want.group_index,
                           out_data.pixel_group, want.pixel_group));
        if (out_data.group_index !== want.group_index)
          report($sformatf("group_index %0d, want %0d", out_data.group_index,
                           want.group_index));
        if (out_data.last !== want.last)
          report($sformatf("group %0d last %b, want %b", want.group_index,
                           out_data.last, want.last));
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int n;
    out_stall <= 1'b1;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold > 0) begin
        n = long_hold;
        long_hold = 0;
      end else begin
        n = $urandom_range(0, rx_max);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(negedge clk);
      while (!out_valid) @(negedge clk);
      @(posedge clk);
    end
  end

  initial begin
    step_t    steps_reset[$];
    step_t    steps_full[$];
    logic [3:0] modes[$];
    tslr_pkg::in_item_t it;
    int       n_items;

    err_cnt   = 0;
    cycles    = 0;
    rx_max    = 14;
    tx_max    = 14;
    long_hold = 0;
    cfg_img   = '0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // after reset everything is off: lines come out blank
    steps_reset = '{
      '{tslr_pkg::OP_RENDER,    13'd0,    8'd0,   8'd0,   1'b1},
      '{tslr_pkg::OP_RENDER,    13'd0,    8'd0,   8'd255, 1'b1},
      '{tslr_pkg::OP_NONE,      13'h1FFF, 8'hFF,  8'hFF,  1'b0},
      '{tslr_pkg::OP_SPRITE_WR, 13'd160,  8'hAA,  8'd0,   1'b0},
      '{tslr_pkg::OP_SPRITE_WR, 13'h1FFF, 8'h55,  8'd0,   1'b0},
      '{tslr_pkg::OP_RENDER,    13'd0,    8'd0,   8'd143, 1'b1}
    };
    foreach (steps_reset[i]) begin
      it = '{steps_reset[i].op, steps_reset[i].addr, steps_reset[i].data,
             steps_reset[i].line};
      send(it, $urandom_range(0, tx_max), steps_reset[i].blank);
    end

    // fill both memories so every later read hits written data
    for (int a = 0; a < tslr_pkg::VIDEO_BYTES; a++)
      send('{tslr_pkg::OP_VRAM_WR, 13'(a), 8'($urandom), 8'($urandom)}, 0, 1'b0);
    for (int a = 0; a < tslr_pkg::SPRITE_BYTES; a++)
      send('{tslr_pkg::OP_SPRITE_WR, 13'(a), 8'($urandom), 8'($urandom)}, 0, 1'b0);

    // extremes with background and sprites on
    set_cfg(4'b1100);
    steps_full = '{
      '{tslr_pkg::OP_VRAM_WR,   13'd0,    8'hFF,  8'd0,   1'b0},
      '{tslr_pkg::OP_VRAM_WR,   13'h1FFF, 8'h00,  8'hFF,  1'b0},
      '{tslr_pkg::OP_VRAM_WR,   13'h1800, 8'h80,  8'd0,   1'b0},
      '{tslr_pkg::OP_VRAM_WR,   13'h1801, 8'h7F,  8'd0,   1'b0},
      '{tslr_pkg::OP_SPRITE_WR, 13'd0,    8'd16,  8'd0,   1'b0},
      '{tslr_pkg::OP_SPRITE_WR, 13'd1,    8'd8,   8'd0,   1'b0},
      '{tslr_pkg::OP_SPRITE_WR, 13'd2,    8'd0,   8'd0,   1'b0},
      '{tslr_pkg::OP_SPRITE_WR, 13'd3,    8'h80,  8'd0,   1'b0},
      '{tslr_pkg::OP_SPRITE_WR, 13'd159,  8'hFF,  8'd0,   1'b0},
      '{tslr_pkg::OP_RENDER,    13'd0,    8'd0,   8'd0,   1'b0},
      '{tslr_pkg::OP_RENDER,    13'd0,    8'd0,   8'd7,   1'b0},
      '{tslr_pkg::OP_RENDER,    13'd0,    8'd0,   8'd8,   1'b0},
      '{tslr_pkg::OP_RENDER,    13'd0,    8'd0,   8'd143, 1'b0},
      '{tslr_pkg::OP_RENDER,    13'd0,    8'd0,   8'd144, 1'b0},
      '{tslr_pkg::OP_RENDER,    13'd0,    8'd0,   8'd255, 1'b0},
      '{tslr_pkg::OP_SPRITE_WR, 13'd1,    8'd0,   8'd0,   1'b0},
      '{tslr_pkg::OP_RENDER,    13'd0,    8'd0,   8'd0,   1'b0},
      '{tslr_pkg::OP_SPRITE_WR, 13'd1,    8'd167, 8'd0,   1'b0},
      '{tslr_pkg::OP_RENDER,    13'd0,    8'd0,   8'd3,   1'b0}
    };
    foreach (steps_full[i]) begin
      it = '{steps_full[i].op, steps_full[i].addr, steps_full[i].data,
             steps_full[i].line};
      send(it, $urandom_range(0, tx_max), steps_full[i].blank);
    end

    // random phases over register settings
    modes = '{4'b1111, 4'b0000, 4'b1010, 4'b0101, 4'b1100, 4'b0011, 4'b1001, 4'b1110};
    foreach (modes[m]) begin
      set_cfg(modes[m]);
      tx_max = (m % 3 == 1) ? 0 : 14;
      rx_max = (m % 3 == 2) ? 0 : 14;
      n_items = 38;
      if (m == 2) long_hold = 1500;
      for (int i = 0; i < n_items; i++) begin
        // one pause until the block has delivered everything
        if (m == 4 && i == n_items / 2) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending_groups.size() != 0) @(posedge clk);
        end
        it = rand_item();
        send(it, $urandom_range(0, tx_max), 1'b0);
      end
    end

    drain();
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
